### hdl/cefp_pkg.sv
// ----------------------------------------------------------------------------
// cefp_pkg
// Shared types and constants of the control event frame parser.
// ----------------------------------------------------------------------------
package cefp_pkg;

    // Frame start marker
    localparam logic [7:0] START_BYTE   = 8'hE9;

    // Frame type codes as they appear in the type byte
    localparam logic [7:0] TYPE_PRESS   = 8'd1;
    localparam logic [7:0] TYPE_RELEASE = 8'd2;
    localparam logic [7:0] TYPE_TURN    = 8'd3;

    // Position inside a frame
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_BTN_ID,
        PH_BTN_SUM,
        PH_DIAL_ID,
        PH_DIAL_CNT,
        PH_DIAL_SUM
    } t_phase;

    // Event kinds on the result channel
    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_TURN    = 2'd2
    } t_kind;

    // One received item
    typedef struct packed {
        logic       gap;
        logic [7:0] rx_byte;
    } t_item;

    // One decoded event
    typedef struct packed {
        t_kind             kind;
        logic [7:0]        control_id;
        logic signed [7:0] turn_count;
    } t_event;

endpackage

### hdl/cefp_if.sv
// ----------------------------------------------------------------------------
// cefp_rx_if / cefp_evt_if
// Valid/ready channels for received bytes and for decoded events.
// ----------------------------------------------------------------------------
interface cefp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       gap;

    modport source (output valid, output rx_byte, output gap, input ready);
    modport sink   (input valid, input rx_byte, input gap, output ready);
endinterface

interface cefp_evt_if;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic [7:0]        control_id;
    logic signed [7:0] turn_count;

    modport source (output valid, output event_kind, output control_id,
                    output turn_count, input ready);
    modport sink   (input valid, input event_kind, input control_id,
                    input turn_count, output ready);
endinterface

### hdl/cefp_in_stage.sv
// ----------------------------------------------------------------------------
// cefp_in_stage
// Input register: captures one received item and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module cefp_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cefp_rx_if.sink         i_rx,
    input  logic            i_consume,
    output logic            o_valid,
    output cefp_pkg::t_item o_item
);

    logic            r_valid;
    cefp_pkg::t_item r_item;

    // Accept a new transfer when empty or when the held item leaves now
    assign i_rx.ready = !r_valid || i_consume;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_item.gap     <= i_rx.gap;
            r_item.rx_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### hdl/cefp_parser.sv
// ----------------------------------------------------------------------------
// cefp_parser
// Frame state machine: hunts for the start byte, collects type, id and
// count, checks the running sum and flags a decoded event.
// ----------------------------------------------------------------------------
module cefp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  cefp_pkg::t_item  i_item,
    output logic             o_evt_valid,
    output cefp_pkg::t_event o_evt
);

    cefp_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_type,  n_type;
    logic [7:0]       r_sum,   n_sum;
    logic [7:0]       r_id,    n_id;
    logic [7:0]       r_cnt,   n_cnt;
    logic [7:0]       sum_add;

    assign sum_add = r_sum + i_item.rx_byte;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cefp_pkg::PH_HUNT;
            r_type  <= 2'd0;
            r_sum   <= 8'd0;
            r_id    <= 8'd0;
            r_cnt   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_sum   <= n_sum;
            r_id    <= n_id;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and event decode
    always_comb begin
        n_phase          = r_phase;
        n_type           = r_type;
        n_sum            = r_sum;
        n_id             = r_id;
        n_cnt            = r_cnt;
        o_evt_valid      = 1'b0;
        o_evt.kind       = (r_phase == cefp_pkg::PH_DIAL_SUM) ? cefp_pkg::KIND_TURN :
                           (r_type == cefp_pkg::TYPE_RELEASE[1:0]) ?
                           cefp_pkg::KIND_RELEASE : cefp_pkg::KIND_PRESS;
        o_evt.control_id = r_id;
        o_evt.turn_count = (r_phase == cefp_pkg::PH_DIAL_SUM) ? r_cnt : 8'sd0;

        if (i_take) begin
            if (i_item.gap) begin
                // Abandon any partial frame
                n_phase = cefp_pkg::PH_HUNT;
                n_sum   = 8'd0;
            end else begin
                case (r_phase)
                    cefp_pkg::PH_TYPE: begin
                        n_sum = sum_add;
                        if (i_item.rx_byte inside {cefp_pkg::TYPE_PRESS,
                                                   cefp_pkg::TYPE_RELEASE}) begin
                            n_type  = i_item.rx_byte[1:0];
                            n_phase = cefp_pkg::PH_BTN_ID;
                        end else if (i_item.rx_byte == cefp_pkg::TYPE_TURN) begin
                            n_type  = cefp_pkg::TYPE_TURN[1:0];
                            n_phase = cefp_pkg::PH_DIAL_ID;
                        end else begin
                            // Unknown type: drop the frame
                            n_phase = cefp_pkg::PH_HUNT;
                            n_sum   = 8'd0;
                        end
                    end
                    cefp_pkg::PH_BTN_ID: begin
                        n_id    = i_item.rx_byte;
                        n_cnt   = 8'd0;
                        n_sum   = sum_add;
                        n_phase = cefp_pkg::PH_BTN_SUM;
                    end
                    cefp_pkg::PH_DIAL_ID: begin
                        n_id    = i_item.rx_byte;
                        n_sum   = sum_add;
                        n_phase = cefp_pkg::PH_DIAL_CNT;
                    end
                    cefp_pkg::PH_DIAL_CNT: begin
                        n_cnt   = i_item.rx_byte;
                        n_sum   = sum_add;
                        n_phase = cefp_pkg::PH_DIAL_SUM;
                    end
                    cefp_pkg::PH_BTN_SUM,
                    cefp_pkg::PH_DIAL_SUM: begin
                        // Emit only on a matching checksum
                        o_evt_valid = (i_item.rx_byte == r_sum);
                        n_phase     = cefp_pkg::PH_HUNT;
                        n_sum       = 8'd0;
                    end
                    default: begin
                        // Hunt for the start byte
                        if (i_item.rx_byte == cefp_pkg::START_BYTE) begin
                            n_sum   = cefp_pkg::START_BYTE;
                            n_phase = cefp_pkg::PH_TYPE;
                        end else begin
                            n_phase = cefp_pkg::PH_HUNT;
                            n_sum   = 8'd0;
                        end
                    end
                endcase
            end
        end
    end

endmodule

### hdl/cefp_out_stage.sv
// ----------------------------------------------------------------------------
// cefp_out_stage
// Result register: holds one decoded event until the receiver takes it.
// ----------------------------------------------------------------------------
module cefp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cefp_pkg::t_event i_evt,
    output logic             o_free,
    cefp_evt_if.source       o_evt
);

    logic             r_valid;
    cefp_pkg::t_event r_evt;

    // Slot can take a new event when empty or drained this cycle
    assign o_free = !r_valid || o_evt.ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_evt <= i_evt;
        end
    end

    assign o_evt.valid      = r_valid;
    assign o_evt.event_kind = r_evt.kind;
    assign o_evt.control_id = r_evt.control_id;
    assign o_evt.turn_count = r_evt.turn_count;

endmodule

### hdl/control_event_frame_parser_core.sv
// ----------------------------------------------------------------------------
// control_event_frame_parser_core
// Parses control event frames from a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx carries one received byte per transfer, or a gap marker (gap = 1)
//   for a receive timeout; a gap abandons any partial frame.
//   o_evt carries one event per valid frame: press, release or dial turn,
//   with the control id and the signed turn count (zero for buttons).
//   A frame is start byte 0xE9, type, id, [count,] checksum; the checksum is
//   the 8-bit sum of all earlier frame bytes. Bad checksums and unknown
//   types drop the frame silently.
// Timing:
//   One transfer per cycle is sustained while o_evt is not stalled. The event
//   for a checksum byte is held in the input register, then loaded into the
//   result register by the state update, and from there shown on o_evt.
// Reset:
//   i_rst_n is synchronous, active low; the parser returns to hunting and
//   both registers empty.
// Stall:
//   While o_evt is stalled with an event held, the next item waits in the
//   input register and i_rx.ready drops until the result register drains.
// ----------------------------------------------------------------------------
module control_event_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cefp_rx_if.sink     i_rx,
    cefp_evt_if.source  o_evt
);

    logic             in_valid;
    cefp_pkg::t_item  in_item;
    logic             out_free;
    logic             consume;
    logic             evt_valid;
    cefp_pkg::t_event evt;

    // Advance the held item whenever the result slot can take an event
    assign consume = in_valid && out_free;

    cefp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_consume (consume),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    cefp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (consume),
        .i_item      (in_item),
        .o_evt_valid (evt_valid),
        .o_evt       (evt)
    );

    cefp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (evt_valid),
        .i_evt   (evt),
        .o_free  (out_free),
        .o_evt   (o_evt)
    );

endmodule

### hdl/cefp_checker.sv
// ----------------------------------------------------------------------------
// cefp_checker
// Port-level checks of the control event frame parser.
// ----------------------------------------------------------------------------
module cefp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [1:0]        i_event_kind,
    input logic [7:0]        i_control_id,
    input logic signed [7:0] i_turn_count
);

    // Hold a stalled event
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_kind)
            && $stable(i_control_id) && $stable(i_turn_count))
        else $error("stalled event changed");

    // Button events carry no turn count
    a_btn_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_kind != cefp_pkg::KIND_TURN |-> i_turn_count == 8'sd0)
        else $error("button event with nonzero turn count");

    // An empty result side never blocks input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // A fresh event follows a matching earlier input transfer
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("event without matching input transfer");

endmodule

bind control_event_frame_parser_core cefp_checker u_cefp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_rx.valid),
    .i_in_ready   (i_rx.ready),
    .i_out_valid  (o_evt.valid),
    .i_out_ready  (o_evt.ready),
    .i_event_kind (o_evt.event_kind),
    .i_control_id (o_evt.control_id),
    .i_turn_count (o_evt.turn_count)
);
